### src/sida_pkg.sv
// Shared constants, types and helpers for the signed integer to decimal ASCII block.
// Depends on nothing; every other file refers to it by scoped names.
package sida_pkg;

	localparam int VALUE_WIDTH_DEF = 32;

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;

	// Decimal digits needed for any w-bit unsigned magnitude: floor(w*log10(2)) + 1.
	function automatic int num_digits(input int w);
		int n;
		n = ((w * 1233) >> 12) + 1;
		return n;
	endfunction

	// Commands from the sequencer to the BCD shift unit.
	typedef struct packed {
		logic load;        // take a new magnitude, clear the digits
		logic dabble;      // one double-dabble step: adjust, shift in next magnitude bit
		logic digit_shift; // drop the top digit, shift digits up by one
	} bcd_ctl_t;

endpackage

### src/sida_bcd_conv.sv
// Bit-serial binary to BCD converter (double dabble) with a digit shift-out path.
// Depends on sida_pkg for the command struct.
module sida_bcd_conv #(
	parameter int VALUE_WIDTH = sida_pkg::VALUE_WIDTH_DEF,
	parameter int NUM_DIGITS  = sida_pkg::num_digits(sida_pkg::VALUE_WIDTH_DEF)
) (
	input  logic                     clk,
	input  sida_pkg::bcd_ctl_t       ctl,
	input  logic [VALUE_WIDTH-1:0]   magnitude,
	output logic [3:0]               top_digit
);

	localparam int BCD_W = 4 * NUM_DIGITS;

	logic [VALUE_WIDTH-1:0] mag_q;
	logic [BCD_W-1:0]       bcd_q;
	logic [BCD_W-1:0]       adj;

	// add 3 to every digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			mag_q <= magnitude;
			bcd_q <= '0;
		end else if (ctl.dabble) begin
			mag_q <= {mag_q[VALUE_WIDTH-2:0], 1'b0};
			bcd_q <= {adj[BCD_W-2:0], mag_q[VALUE_WIDTH-1]};
		end else if (ctl.digit_shift) begin
			bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
		end
	end

	assign top_digit = bcd_q[BCD_W-1 -: 4];

endmodule

### src/signed_int_to_decimal_ascii_top.sv
// Sequence: accept, then ST_CONV (one dabble step per input bit), ST_SIGN ('-' for negatives),
//   ST_SKIP (drop leading zero digits) and ST_EMIT (one digit per output word).
// Pace: a new number is taken only after the last digit of the previous one has gone to the
//   output register; output stalls hold ST_SIGN and ST_EMIT, and the serial BCD shift register sets the pace.
// Reset: arst_n clears the sequencer and the output valid; data registers keep garbage.
// Depends on sida_pkg and sida_bcd_conv.
module signed_int_to_decimal_ascii_top #(
	parameter int VALUE_WIDTH = sida_pkg::VALUE_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// slave side: tdata = {zero pad, value[VALUE_WIDTH-1:0]}
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [((VALUE_WIDTH+7)/8)*8-1:0]      s_tdata,
	// master side: tdata = {4'b0, char_count[3:0], ascii_char[7:0]}, tlast = is_last
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [15:0]                           m_tdata,
	output logic                                  m_tlast
);

	localparam int NUM_DIGITS = sida_pkg::num_digits(VALUE_WIDTH);
	localparam int CNT_W      = $clog2(VALUE_WIDTH + 1);
	localparam int DL_W       = $clog2(NUM_DIGITS + 1);
	localparam int CC_W       = $clog2(NUM_DIGITS + 2);

	// sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CONV = 3'd1; // double dabble, one input bit per cycle
	localparam logic [2:0] ST_SIGN = 3'd2; // send '-' for negatives
	localparam logic [2:0] ST_SKIP = 3'd3; // drop leading zero digits
	localparam logic [2:0] ST_EMIT = 3'd4; // send one digit per word

	logic [2:0]             state_q;
	logic [CNT_W-1:0]       cnt_q;      // dabble steps left
	logic [DL_W-1:0]        dleft_q;    // digits left in the BCD register
	logic [CC_W-1:0]        ccount_q;   // characters sent so far
	logic                   neg_q;

	logic                   m_tvalid_q;
	logic [7:0]             char_q;
	logic                   last_q;
	logic [3:0]             count_q;

	logic [VALUE_WIDTH-1:0] value;
	logic                   neg;
	logic [VALUE_WIDTH-1:0] magnitude;
	logic [3:0]             top_digit;
	logic                   out_free;
	logic                   emit_sign;
	logic                   emit_dig;
	logic                   skip_zero;
	logic [CC_W-1:0]        ccount_next;
	sida_pkg::bcd_ctl_t     ctl;

	// magnitude one bit past the sign: the most negative value comes out as 2^(W-1)
	assign value     = s_tdata[VALUE_WIDTH-1:0];
	assign neg       = value[VALUE_WIDTH-1];
	assign magnitude = neg ? (~value + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : value;

	assign s_tready  = (state_q == ST_IDLE);
	assign out_free  = !m_tvalid_q || m_tready;
	assign emit_sign = (state_q == ST_SIGN) && neg_q && out_free;
	assign emit_dig  = (state_q == ST_EMIT) && out_free;
	// keep at least one digit so zero still prints '0'
	assign skip_zero = (state_q == ST_SKIP) && (top_digit == 4'd0) &&
		(dleft_q > DL_W'(1));
	assign ccount_next = ccount_q + CC_W'(1);

	always_comb begin
		ctl.load        = s_tvalid && s_tready;
		ctl.dabble      = (state_q == ST_CONV);
		ctl.digit_shift = skip_zero || emit_dig;
	end

	sida_bcd_conv #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.NUM_DIGITS  (NUM_DIGITS)
	) u_conv (
		.clk       (clk),
		.ctl       (ctl),
		.magnitude (magnitude),
		.top_digit (top_digit)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			dleft_q  <= '0;
			ccount_q <= '0;
			neg_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						neg_q   <= neg;
						cnt_q   <= CNT_W'(VALUE_WIDTH);
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == CNT_W'(1)) begin
						state_q <= ST_SIGN;
					end
				end
				ST_SIGN: begin
					dleft_q <= DL_W'(NUM_DIGITS);
					if (!neg_q) begin
						ccount_q <= '0;
						state_q  <= ST_SKIP;
					end else if (out_free) begin
						ccount_q <= CC_W'(1);
						state_q  <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					if (skip_zero) begin
						dleft_q <= dleft_q - DL_W'(1);
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						dleft_q  <= dleft_q - DL_W'(1);
						ccount_q <= ccount_next;
						if (dleft_q == DL_W'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output word register; holds while the consumer stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit_sign || emit_dig) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_sign) begin
			char_q  <= sida_pkg::CHAR_MINUS;
			last_q  <= 1'b0;
			count_q <= 4'd0;
		end else if (emit_dig) begin
			char_q <= sida_pkg::CHAR_ZERO + {4'd0, top_digit};
			if (dleft_q == DL_W'(1)) begin
				last_q  <= 1'b1;
				count_q <= ccount_next[3:0];
			end else begin
				last_q  <= 1'b0;
				count_q <= 4'd0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'd0, count_q, char_q};
	assign m_tlast  = last_q;

endmodule

### src/sida_checker.sv
// Port-level checks for signed_int_to_decimal_ascii_top, attached by bind.
// Depends on sida_pkg for the character codes.
module sida_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tlast
);

	// a stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output word changed while stalled");

	// one number at a time: no second accept right after one
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while converting");

	// count only on the last word
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tdata[11:8] == 4'd0)
		else $error("char count on a non-final word");

	// the last word is a digit
	a_last_digit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[7:0] >= sida_pkg::CHAR_ZERO &&
			m_tdata[7:0] <= sida_pkg::CHAR_ZERO + 8'd9)
		else $error("final word is not a digit");

	// every word is a digit or the minus sign
	a_charset: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[7:0] != sida_pkg::CHAR_MINUS |->
			m_tdata[7:0] >= sida_pkg::CHAR_ZERO && m_tdata[7:0] <= sida_pkg::CHAR_ZERO + 8'd9)
		else $error("illegal output character");

endmodule

bind signed_int_to_decimal_ascii_top sida_checker u_sida_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
